// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define TRD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("trd assertion failed");
`define TRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trd assertion failed");
`else
`define TRD_ASSERT(lbl, prop)
`define TRD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Types, widths and constants of the triangle raster and depth test unit.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int DEF_WIDTH  = 64;
    localparam int DEF_HEIGHT = 64;

    localparam int OP_W      = 2;
    localparam int COORD_W   = 12;
    localparam int Z_W       = 16;
    localparam int RC_W      = 6;
    localparam int DEPTH_W   = 17;
    localparam int COLOR_W   = 32;
    localparam int COUNT_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam int DIFF_W  = 13;
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = 45;
    localparam int NUM_W   = 46;
    localparam int DEN_W   = 28;
    localparam int Q_W     = 16;

    localparam logic [DEPTH_W-1:0] DEPTH_INF = 17'h0FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;
    localparam logic [COLOR_W-1:0] FILL_RST  = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] CLEAR_RST = 32'h0000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_DRAW      = 2'd0,
        OP_CLR_DEPTH = 2'd1,
        OP_CLR_COLOR = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_AREA,
        S_SETUP,
        S_EDGE,
        S_TEST,
        S_ZSUM,
        S_DIV,
        S_WRITE,
        S_CLR_D,
        S_CLR_C,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/core/trd_div.sv
// ----------------------------------------------------------------------------
// trd_div
// Restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module trd_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [trd_pkg::NUM_W-1:0]    num,
    input  logic        [trd_pkg::DEN_W-1:0]    den,
    output trd_pkg::div_stat_t                  stat,
    output logic signed [trd_pkg::DEPTH_W-1:0]  quot
);
    import trd_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic             neg_reg;
    logic             fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            rem_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dsh_reg <= {{(NUM_W-DEN_W){1'b0}}, den} << (Q_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

// File: rtl/core/triangle_raster_depth_test_unit.sv
// ----------------------------------------------------------------------------
// triangle_raster_depth_test_unit
// Edge-function triangle rasterizer with depth test over on-chip stores.
// ----------------------------------------------------------------------------
// Draw: setup, then per bounding-box pixel the edge products, and when covered
// the depth sum, both on one shared multiplier, and a 16-step divide; then the
// result is loaded. Clears sweep every address of their store before giving
// their result; the next item is taken in the cycle after the result is
// loaded, even while that result waits. After reset a clearing pass over both
// stores runs before the first item.
`include "assert_macros.svh"

module triangle_raster_depth_test_unit #(
    parameter int WIDTH  = trd_pkg::DEF_WIDTH,
    parameter int HEIGHT = trd_pkg::DEF_HEIGHT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic        [trd_pkg::OP_W-1:0]       opcode,
    input  logic signed [trd_pkg::COORD_W-1:0]    x0,
    input  logic signed [trd_pkg::COORD_W-1:0]    y0,
    input  logic signed [trd_pkg::COORD_W-1:0]    x1,
    input  logic signed [trd_pkg::COORD_W-1:0]    y1,
    input  logic signed [trd_pkg::COORD_W-1:0]    x2,
    input  logic signed [trd_pkg::COORD_W-1:0]    y2,
    input  logic signed [trd_pkg::Z_W-1:0]        z0,
    input  logic signed [trd_pkg::Z_W-1:0]        z1,
    input  logic signed [trd_pkg::Z_W-1:0]        z2,
    input  logic        [trd_pkg::RC_W-1:0]       read_col,
    input  logic        [trd_pkg::RC_W-1:0]       read_row,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [trd_pkg::COLOR_W-1:0]    read_color,
    output logic signed [trd_pkg::DEPTH_W-1:0]    read_depth,
    output logic        [trd_pkg::COUNT_W-1:0]    pixels_written,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [trd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [trd_pkg::CFG_W-1:0]      cfg_data
);
    import trd_pkg::*;

    localparam int NPIX   = WIDTH * HEIGHT;
    localparam int ADDR_W = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int PX_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int PY_W   = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam logic signed [DIFF_W-1:0] XMAX = DIFF_W'(WIDTH - 1);
    localparam logic signed [DIFF_W-1:0] YMAX = DIFF_W'(HEIGHT - 1);

    logic [DEPTH_W-1:0] depth_mem [NPIX];
    logic [COLOR_W-1:0] color_mem [NPIX];

    state_t state_reg, state_next;
    logic [2:0]        step_reg, step_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic              sweep_end;
    logic              out_valid_reg;
    logic [COLOR_W-1:0] fill_reg, clear_reg;

    logic signed [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [Z_W-1:0]     z0_reg, z1_reg, z2_reg;
    op_t                       op_reg;
    logic [PX_W-1:0]           bx0_reg, bx1_reg, px_reg;
    logic [PY_W-1:0]           by0_reg, by1_reg, py_reg;
    logic                      empty_reg;
    logic signed [MUL_A_W-1:0] area_reg, w0_reg, w1_reg, w2_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      rd_ok_reg;
    logic [DEPTH_W-1:0]        depth_rd_reg;
    logic [COLOR_W-1:0]        color_rd_reg;
    logic [COLOR_W-1:0]        color_out_reg;
    logic signed [DEPTH_W-1:0] depth_out_reg;
    logic [COUNT_W-1:0]        count_out_reg;

    logic in_acc, adv, last_px, last_py, covered, pass, out_load;
    logic div_start;
    div_stat_t div_stat;
    logic signed [DEPTH_W-1:0] quot;
    logic depth_we, color_we, depth_rd_en;
    logic [ADDR_W-1:0] di, ci, ra, depth_waddr, color_waddr, depth_raddr;
    logic [DEPTH_W-1:0] depth_wdata;
    logic [COLOR_W-1:0] color_wdata;
    logic rd_ok;

    logic signed [DIFF_W-1:0] ax, ay, bx, by, ptx, pty, dab, dpt;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [COORD_W-1:0] xmn, xmx, ymn, ymx;
    logic signed [DIFF_W-1:0]  xlo, xhi, ylo, yhi;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign read_color     = color_out_reg;
    assign read_depth     = depth_out_reg;
    assign pixels_written = count_out_reg;

    assign sweep_end = (cnt_reg == ADDR_W'(NPIX - 1));
    assign last_px   = (px_reg == bx1_reg);
    assign last_py   = (py_reg == by1_reg);
    assign covered   = !w0_reg[MUL_A_W-1] && !w1_reg[MUL_A_W-1] && !w2_reg[MUL_A_W-1];
    assign pass      = quot < $signed(depth_rd_reg);

    assign di = ADDR_W'(int'(py_reg) * WIDTH + int'(px_reg));
    assign ci = ADDR_W'((HEIGHT - 1 - int'(py_reg)) * WIDTH + int'(px_reg));
    assign ra = ADDR_W'(int'(read_row) * WIDTH + int'(read_col));
    assign rd_ok = (int'(read_col) < WIDTH) && (int'(read_row) < HEIGHT);

    // bounding box, clamped to the target
    always_comb
    begin
        xmn = (x0 < x1) ? x0 : x1;
        xmn = (xmn < x2) ? xmn : x2;
        xmx = (x0 > x1) ? x0 : x1;
        xmx = (xmx > x2) ? xmx : x2;
        ymn = (y0 < y1) ? y0 : y1;
        ymn = (ymn < y2) ? ymn : y2;
        ymx = (y0 > y1) ? y0 : y1;
        ymx = (ymx > y2) ? ymx : y2;
        xlo = (xmn < 0) ? '0 : DIFF_W'(xmn);
        ylo = (ymn < 0) ? '0 : DIFF_W'(ymn);
        xhi = (DIFF_W'(xmx) > XMAX) ? XMAX : DIFF_W'(xmx);
        yhi = (DIFF_W'(ymx) > YMAX) ? YMAX : DIFF_W'(ymx);
    end

    // shared multiplier operands
    always_comb
    begin
        ax = DIFF_W'(x0_reg);
        ay = DIFF_W'(y0_reg);
        bx = DIFF_W'(x1_reg);
        by = DIFF_W'(y1_reg);
        ptx = DIFF_W'(x2_reg);
        pty = DIFF_W'(y2_reg);
        if (state_reg != S_AREA)
        begin
            ptx = $signed(DIFF_W'(px_reg));
            pty = $signed(DIFF_W'(py_reg));
            unique case (step_reg[2:1])
                2'd0:
                begin
                    ax = DIFF_W'(x1_reg);
                    ay = DIFF_W'(y1_reg);
                    bx = DIFF_W'(x2_reg);
                    by = DIFF_W'(y2_reg);
                end
                2'd1:
                begin
                    ax = DIFF_W'(x2_reg);
                    ay = DIFF_W'(y2_reg);
                    bx = DIFF_W'(x0_reg);
                    by = DIFF_W'(y0_reg);
                end
                default:
                begin
                    ax = DIFF_W'(x0_reg);
                    ay = DIFF_W'(y0_reg);
                    bx = DIFF_W'(x1_reg);
                    by = DIFF_W'(y1_reg);
                end
            endcase
        end
        dab = step_reg[0] ? (by - ay) : (bx - ax);
        dpt = step_reg[0] ? (ptx - ax) : (pty - ay);
        mul_a = MUL_A_W'(dab);
        mul_b = MUL_B_W'(dpt);
        if (state_reg == S_ZSUM)
        begin
            unique case (step_reg[1:0])
                2'd0:
                begin
                    mul_a = w0_reg;
                    mul_b = MUL_B_W'(z0_reg);
                end
                2'd1:
                begin
                    mul_a = w1_reg;
                    mul_b = MUL_B_W'(z1_reg);
                end
                default:
                begin
                    mul_a = w2_reg;
                    mul_b = MUL_B_W'(z2_reg);
                end
            endcase
        end
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        div_start  = 1'b0;
        adv        = 1'b0;
        depth_we   = 1'b0;
        color_we   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                depth_we = 1'b1;
                color_we = 1'b1;
                if (sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                step_next = '0;
                if (in_acc)
                begin
                    unique case (op_t'(opcode))
                        OP_DRAW:      state_next = S_AREA;
                        OP_CLR_DEPTH: state_next = S_CLR_D;
                        OP_CLR_COLOR: state_next = S_CLR_C;
                        OP_READ:      state_next = S_FINISH;
                    endcase
                end
            end
            S_AREA:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd2)
                begin
                    step_next  = '0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = (area_reg > 0 && !empty_reg) ? S_EDGE : S_FINISH;
            end
            S_EDGE:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    step_next  = '0;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (covered)
                begin
                    state_next = S_ZSUM;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_ZSUM:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_reg == 3'd0)
                begin
                    div_start = 1'b1;
                    step_next = 3'd1;
                end
                else if (div_stat.done)
                begin
                    step_next  = '0;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                depth_we = pass;
                color_we = pass;
                adv      = 1'b1;
            end
            S_CLR_D:
            begin
                depth_we = 1'b1;
                if (sweep_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_CLR_C:
            begin
                color_we = 1'b1;
                if (sweep_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (adv)
        begin
            state_next = (last_px && last_py) ? S_FINISH : S_EDGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            fill_reg      <= FILL_RST;
            clear_reg     <= CLEAR_RST;
        end
        else
        begin
            if (state_reg == S_INIT || state_reg == S_CLR_D || state_reg == S_CLR_C)
            begin
                cnt_reg <= sweep_end ? '0 : cnt_reg + ADDR_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FILL)
                begin
                    fill_reg <= cfg_data;
                end
                else if (cfg_index == CFG_CLEAR)
                begin
                    clear_reg <= cfg_data;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (in_acc)
        begin
            op_reg    <= op_t'(opcode);
            x0_reg    <= x0;
            y0_reg    <= y0;
            x1_reg    <= x1;
            y1_reg    <= y1;
            x2_reg    <= x2;
            y2_reg    <= y2;
            z0_reg    <= z0;
            z1_reg    <= z1;
            z2_reg    <= z2;
            bx0_reg   <= PX_W'(xlo);
            bx1_reg   <= PX_W'(xhi);
            by0_reg   <= PY_W'(ylo);
            by1_reg   <= PY_W'(yhi);
            empty_reg <= (xlo > xhi) || (ylo > yhi);
            rd_ok_reg <= rd_ok;
            count_reg <= '0;
        end
        if (state_reg == S_AREA)
        begin
            if (step_reg == 3'd1)
            begin
                area_reg <= MUL_A_W'(prod_reg);
            end
            else if (step_reg == 3'd2)
            begin
                area_reg <= area_reg - MUL_A_W'(prod_reg);
            end
        end
        if (state_reg == S_SETUP)
        begin
            px_reg <= bx0_reg;
            py_reg <= by0_reg;
        end
        if (state_reg == S_EDGE)
        begin
            unique case (step_reg)
                3'd1:    w0_reg <= MUL_A_W'(prod_reg);
                3'd2:    w0_reg <= w0_reg - MUL_A_W'(prod_reg);
                3'd3:    w1_reg <= MUL_A_W'(prod_reg);
                3'd4:    w1_reg <= w1_reg - MUL_A_W'(prod_reg);
                3'd5:    w2_reg <= MUL_A_W'(prod_reg);
                3'd6:    w2_reg <= w2_reg - MUL_A_W'(prod_reg);
                default: ;
            endcase
        end
        if (state_reg == S_ZSUM)
        begin
            if (step_reg == 3'd1)
            begin
                num_reg <= NUM_W'(prod_reg);
            end
            else if (step_reg != 3'd0)
            begin
                num_reg <= num_reg + NUM_W'(prod_reg);
            end
        end
        if (state_reg == S_WRITE && pass && count_reg != COUNT_MAX)
        begin
            count_reg <= count_reg + COUNT_W'(1);
        end
        if (adv)
        begin
            if (last_py)
            begin
                py_reg <= by0_reg;
                px_reg <= px_reg + PX_W'(1);
            end
            else
            begin
                py_reg <= py_reg + PY_W'(1);
            end
        end
        if (out_load)
        begin
            color_out_reg <= (op_reg == OP_READ && rd_ok_reg) ? color_rd_reg : '0;
            depth_out_reg <= (op_reg == OP_READ && rd_ok_reg) ? $signed(depth_rd_reg) : '0;
            count_out_reg <= (op_reg == OP_DRAW) ? count_reg : '0;
        end
    end

    // store ports
    assign depth_rd_en = (state_reg == S_EDGE && step_reg == 3'd0)
                      || (in_acc && op_t'(opcode) == OP_READ);
    assign depth_raddr = (state_reg == S_EDGE) ? di : ra;
    assign depth_waddr = (state_reg == S_WRITE) ? di : cnt_reg;
    assign depth_wdata = (state_reg == S_WRITE) ? DEPTH_W'(quot) : DEPTH_INF;
    assign color_waddr = (state_reg == S_WRITE) ? ci : cnt_reg;
    assign color_wdata = (state_reg == S_WRITE) ? fill_reg :
                         (state_reg == S_CLR_C) ? clear_reg : CLEAR_RST;

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[depth_waddr] <= depth_wdata;
        end
        if (depth_rd_en)
        begin
            depth_rd_reg <= depth_mem[depth_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[color_waddr] <= color_wdata;
        end
        if (in_acc && op_t'(opcode) == OP_READ)
        begin
            color_rd_reg <= color_mem[ra];
        end
    end

    trd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   ($unsigned(area_reg)),
        .stat  (div_stat),
        .quot  (quot)
    );

    `TRD_ASSERT(a_div_start_idle, !(div_start && div_stat.busy))
    `TRD_ASSERT(a_depth_we_state, !depth_we || state_reg == S_INIT || state_reg == S_CLR_D || state_reg == S_WRITE)
    `TRD_ASSERT_NEXT(a_div_done_write, state_reg == S_DIV && step_reg != 3'd0 && div_stat.done, state_reg == S_WRITE)
    `TRD_ASSERT_NEXT(a_load_valid, out_load, out_valid)

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle raster and depth test unit. A local
// model of both stores predicts every result. Directed items cover reads,
// special triangles and clears, then random traffic runs under three
// idle/stall mixes, with configuration register writes between phases.
// ----------------------------------------------------------------------------
module tb;
    import trd_pkg::*;

    localparam int W = DEF_WIDTH;
    localparam int H = DEF_HEIGHT;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        op_t                       op;
        logic signed [COORD_W-1:0] vx [3];
        logic signed [COORD_W-1:0] vy [3];
        logic signed [Z_W-1:0]     vz [3];
        logic [RC_W-1:0]           col;
        logic [RC_W-1:0]           row;
    } item_t;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [DEPTH_W-1:0] depth;
        logic [COUNT_W-1:0] count;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [OP_W-1:0] opcode = '0;
    logic signed [COORD_W-1:0] x0 = '0, y0 = '0, x1 = '0, y1 = '0, x2 = '0, y2 = '0;
    logic signed [Z_W-1:0] z0 = '0, z1 = '0, z2 = '0;
    logic [RC_W-1:0] read_col = '0, read_row = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [COLOR_W-1:0] read_color;
    logic signed [DEPTH_W-1:0] read_depth;
    logic [COUNT_W-1:0] pixels_written;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    longint depth_mem [W*H];
    logic [COLOR_W-1:0] color_mem [W*H];
    logic [COLOR_W-1:0] fill_color;
    logic [COLOR_W-1:0] clear_color;

    result_t expected_q [$];
    int error_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    longint cycle_count = 0;

    triangle_raster_depth_test_unit dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("tb: mismatch %s got %0h want %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        result_t e;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report("unexpected transfer", 0, 0);
            else
            begin
                e = expected_q.pop_front();
                if (read_color !== e.color) report("read_color", read_color, e.color);
                if (read_depth !== e.depth) report("read_depth", read_depth, e.depth);
                if (pixels_written !== e.count)
                    report("pixels_written", pixels_written, e.count);
            end
        end
    end

    function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy);
        return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    endfunction

    function automatic logic [COUNT_W-1:0] raster_triangle(input item_t it);
        longint ax, ay, bx, by, cx, cy, area, lx, ly, hx, hy, w0, w1, w2, z;
        int cnt;
        ax = it.vx[0]; ay = it.vy[0];
        bx = it.vx[1]; by = it.vy[1];
        cx = it.vx[2]; cy = it.vy[2];
        cnt = 0;
        area = edge_fn(ax, ay, bx, by, cx, cy);
        if (area <= 0)
            return '0;
        lx = ax < bx ? ax : bx; lx = lx < cx ? lx : cx;
        ly = ay < by ? ay : by; ly = ly < cy ? ly : cy;
        hx = ax > bx ? ax : bx; hx = hx > cx ? hx : cx;
        hy = ay > by ? ay : by; hy = hy > cy ? hy : cy;
        if (lx < 0) lx = 0;
        if (ly < 0) ly = 0;
        if (hx > W - 1) hx = W - 1;
        if (hy > H - 1) hy = H - 1;
        for (longint px = lx; px <= hx; px++)
            for (longint py = ly; py <= hy; py++)
            begin
                w0 = edge_fn(bx, by, cx, cy, px, py);
                w1 = edge_fn(cx, cy, ax, ay, px, py);
                w2 = edge_fn(ax, ay, bx, by, px, py);
                if (w0 >= 0 && w1 >= 0 && w2 >= 0)
                begin
                    z = (longint'(it.vz[0]) * w0 + longint'(it.vz[1]) * w1
                         + longint'(it.vz[2]) * w2) / area;
                    if (z < depth_mem[py*W + px])
                    begin
                        depth_mem[py*W + px] = z;
                        color_mem[(H - 1 - py)*W + px] = fill_color;
                        if (cnt < COUNT_MAX) cnt++;
                    end
                end
            end
        return COUNT_W'(cnt);
    endfunction

    function automatic result_t predict_result(input item_t it);
        result_t r;
        r = '{default: '0};
        case (it.op)
            OP_DRAW: r.count = raster_triangle(it);
            OP_CLR_DEPTH: foreach (depth_mem[i]) depth_mem[i] = DEPTH_INF;
            OP_CLR_COLOR: foreach (color_mem[i]) color_mem[i] = clear_color;
            default:
                if (it.col < W && it.row < H)
                begin
                    r.color = color_mem[it.row*W + it.col];
                    r.depth = depth_mem[it.row*W + it.col][DEPTH_W-1:0];
                end
        endcase
        return r;
    endfunction

    task automatic send_item(input item_t it);
        result_t r;
        opcode <= it.op;
        x0 <= it.vx[0]; y0 <= it.vy[0];
        x1 <= it.vx[1]; y1 <= it.vy[1];
        x2 <= it.vx[2]; y2 <= it.vy[2];
        z0 <= it.vz[0]; z1 <= it.vz[1]; z2 <= it.vz[2];
        read_col <= it.col; read_row <= it.row;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        r = predict_result(it);
        expected_q = {expected_q, r};
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FILL) fill_color = val;
        else if (idx == CFG_CLEAR) clear_color = val;
    endtask

    function automatic item_t make_item(input op_t op);
        item_t it;
        it.op = op;
        for (int k = 0; k < 3; k++)
        begin
            it.vx[k] = COORD_W'($urandom);
            it.vy[k] = COORD_W'($urandom);
            it.vz[k] = Z_W'($urandom);
        end
        it.col = RC_W'($urandom);
        it.row = RC_W'($urandom);
        return it;
    endfunction

    function automatic item_t make_tri(input int ax, ay, bx, by, cx, cy,
                                       input int za, zb, zc);
        item_t it;
        it = make_item(OP_DRAW);
        it.vx = '{COORD_W'(ax), COORD_W'(bx), COORD_W'(cx)};
        it.vy = '{COORD_W'(ay), COORD_W'(by), COORD_W'(cy)};
        it.vz = '{Z_W'(za), Z_W'(zb), Z_W'(zc)};
        return it;
    endfunction

    function automatic item_t make_read(input int c, r);
        item_t it;
        it = make_item(OP_READ);
        it.col = RC_W'(c);
        it.row = RC_W'(r);
        return it;
    endfunction

    function automatic item_t small_tri();
        int bx, by;
        bx = $urandom_range(71) - 4;
        by = $urandom_range(71) - 4;
        return make_tri(bx, by, bx + $urandom_range(12) - 6, by + $urandom_range(12) - 6,
                        bx + $urandom_range(12) - 6, by + $urandom_range(12) - 6,
                        $urandom, $urandom, $urandom);
    endfunction

    task automatic test_reads_after_reset();
        send_item(make_read(0, 0));
        send_item(make_read(63, 63));
        send_item(make_read(0, 63));
        send_item(make_read(63, 0));
    endtask

    task automatic test_draw_special_cases();
        send_item(make_tri(0, 0, 4, 0, 0, 4, 100, 200, 300));
        send_item(make_read(1, 1));
        send_item(make_read(1, 62));
        send_item(make_tri(0, 0, 0, 4, 4, 0, -5, -5, -5));
        send_item(make_tri(1, 1, 5, 5, 9, 9, 0, 0, 0));
        send_item(make_tri(-100, -100, -90, -100, -100, -90, -32768, -32768, -32768));
        send_item(make_tri(70, 70, 90, 70, 70, 90, 0, 0, 0));
        send_item(make_tri(-2048, -2048, 2047, -2048, -2048, 2047, 32767, -32768, 0));
        send_item(make_tri(-2048, -2048, 2047, -2048, -2048, 2047, -32768, -32768, -32768));
        send_item(make_tri(-2048, -2048, 2047, -2048, -2048, 2047, 32767, 32767, 32767));
        send_item(make_read(10, 10));
        send_item(make_read(63, 0));
        send_item(make_tri(2, 2, 2, 2, 2, 2, 0, 0, 0));
    endtask

    task automatic test_clears();
        write_register(CFG_CLEAR, 32'hFFFF_FFFF);
        send_item(make_item(OP_CLR_COLOR));
        send_item(make_item(OP_CLR_DEPTH));
        send_item(make_read(5, 5));
        write_register(CFG_CLEAR, 32'h0000_0000);
        write_register(CFG_FILL, 32'h0000_0000);
        send_item(make_tri(0, 0, 10, 0, 0, 10, 32767, 0, -32768));
        send_item(make_read(2, 2));
        send_item(make_read(2, 61));
        send_item(make_item(OP_CLR_COLOR));
        send_item(make_read(2, 61));
    endtask

    task automatic test_random_traffic(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55) send_item(small_tri());
            else if (pick < 57) send_item(make_item(OP_DRAW));
            else if (pick < 88) send_item(make_item(OP_READ));
            else if (pick < 94) send_item(make_item(OP_CLR_DEPTH));
            else send_item(make_item(OP_CLR_COLOR));
        end
    endtask

    initial
    begin
        fill_color = FILL_RST;
        clear_color = CLEAR_RST;
        foreach (depth_mem[i]) depth_mem[i] = DEPTH_INF;
        foreach (color_mem[i]) color_mem[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 27; stall_pct = 69;
        test_reads_after_reset();
        test_draw_special_cases();
        test_clears();

        write_register(CFG_FILL, $urandom);
        write_register(CFG_CLEAR, $urandom);
        test_random_traffic(38);

        idle_pct = 69; stall_pct = 27;
        write_register(CFG_FILL, 32'hFFFF_FFFF);
        write_register(CFG_SPARE_A, $urandom);
        write_register(CFG_SPARE_B, $urandom);
        test_random_traffic(38);

        idle_pct = 0; stall_pct = 0;
        write_register(CFG_FILL, $urandom);
        write_register(CFG_CLEAR, $urandom);
        test_random_traffic(38);

        drain();
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
